@@ src/tpli_pkg.sv @@
// tpli_pkg: widths, codes, reset values and shared types for the
// two point line intersection block; used by every module under src
package tpli_pkg;

    // field widths
    localparam int XY_W           = 12;
    localparam int COORD_BITS_DEF = 12;
    localparam int ACT_W          = 2;
    localparam int PH_W           = 2;
    localparam int COEF_W         = 13;
    localparam int C_W            = 26;
    localparam int DET_W          = 26;
    localparam int PRD_W          = 39;
    localparam int NUM_W          = 40;
    localparam int DSR_W          = 25;
    localparam int Q_W            = 32;
    localparam int DIV_STEPS      = NUM_W / 2;
    localparam int Q_DEPTH        = 2;

    // bus widths
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int S_TDATA_W   = 2 * XY_W;
    localparam int M_TDATA_W   = 128;
    localparam int RES_BITS    = PH_W + 2 * COEF_W + C_W + 2 * Q_W + 4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PLACE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PREVIEW = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

    // phase codes
    localparam logic [PH_W-1:0] PH_NONE  = 2'd0;
    localparam logic [PH_W-1:0] PH_FIRST = 2'd1;
    localparam logic [PH_W-1:0] PH_LINE  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_FSX = 2'd0;
    localparam logic [1:0] REG_FSY = 2'd1;
    localparam logic [1:0] REG_FEX = 2'd2;
    localparam logic [1:0] REG_FEY = 2'd3;

    // register reset values
    localparam logic [XY_W-1:0] FSX_RST = 12'd100;
    localparam logic [XY_W-1:0] FSY_RST = 12'd300;
    localparam logic [XY_W-1:0] FEX_RST = 12'd860;
    localparam logic [XY_W-1:0] FEY_RST = 12'd300;

    // saturation bounds
    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic            eval;
        logic [PH_W-1:0] phase;
        logic [XY_W-1:0] x1;
        logic [XY_W-1:0] y1;
        logic [XY_W-1:0] x2;
        logic [XY_W-1:0] y2;
    } t_job;

    typedef struct packed {
        logic [XY_W-1:0] sx;
        logic [XY_W-1:0] sy;
        logic [XY_W-1:0] ex;
        logic [XY_W-1:0] ey;
    } t_cfg;

    typedef struct packed {
        logic                     saturated;
        logic                     is_perpendicular;
        logic                     is_parallel;
        logic                     crossing_found;
        logic signed [Q_W-1:0]    cross_y;
        logic signed [Q_W-1:0]    cross_x;
        logic signed [C_W-1:0]    coef_c;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_a;
        logic [PH_W-1:0]          phase;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dvd;
        logic [DSR_W-1:0] dsr;
    } t_div_req;

endpackage

@@ src/tpli_front.sv @@
// tpli_front: accepts point beats, keeps the held first point and phase,
// and turns each beat into a job for the back end; uses tpli_pkg
module tpli_front
    import tpli_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ACT_W-1:0] i_action,
    input  logic [XY_W-1:0]  i_px,
    input  logic [XY_W-1:0]  i_py,
    output logic             o_push,
    output t_job             o_job,
    input  logic             i_full
);

    localparam int EFF_BITS = (COORD_BITS < XY_W) ? COORD_BITS : XY_W;
    localparam logic [XY_W-1:0] CMASK = {XY_W{1'b1}} >> (XY_W - EFF_BITS);

    logic [PH_W-1:0] r_phase, n_phase;
    logic [XY_W-1:0] r_first_x, n_first_x;
    logic [XY_W-1:0] r_first_y, n_first_y;
    logic            eval;
    logic [XY_W-1:0] px, py;

    assign px      = i_px & CMASK;
    assign py      = i_py & CMASK;
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // classify the beat against the held phase
    always_comb begin
        n_phase   = r_phase;
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        eval      = 1'b0;
        unique case (i_action)
            ACT_PLACE: begin
                if (r_phase == PH_FIRST) begin
                    eval    = 1'b1;
                    n_phase = PH_LINE;
                end else begin
                    n_first_x = px;
                    n_first_y = py;
                    n_phase   = PH_FIRST;
                end
            end
            ACT_PREVIEW: begin
                eval = (r_phase == PH_FIRST);
            end
            ACT_CLEAR: begin
                n_phase   = PH_NONE;
                n_first_x = '0;
                n_first_y = '0;
            end
            default: begin
                eval = 1'b0;
            end
        endcase
    end

    // job for the back end
    always_comb begin
        o_job.eval  = eval;
        o_job.phase = n_phase;
        o_job.x1    = r_first_x;
        o_job.y1    = r_first_y;
        o_job.x2    = px;
        o_job.y2    = py;
    end

    // held point and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NONE;
            r_first_x <= '0;
            r_first_y <= '0;
        end else if (o_push) begin
            r_phase   <= n_phase;
            r_first_x <= n_first_x;
            r_first_y <= n_first_y;
        end
    end

endmodule

@@ src/tpli_queue.sv @@
// tpli_queue: short job queue between front and back end
// depends on tpli_pkg for the job type and depth
module tpli_queue
    import tpli_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_job             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from empty queue");
`endif

endmodule

@@ src/tpli_div.sv @@
// tpli_div: unsigned restoring divider, two quotient bits per cycle
// depends on tpli_pkg for operand widths
module tpli_div
    import tpli_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_q;
    logic [DSR_W-1:0]   r_rem;
    logic [DSR_W-1:0]   r_dsr;
    logic [DSR_W:0]     t1, t2;
    logic               ge1, ge2;
    logic [DSR_W-1:0]   rem1, rem2;

    // two dependent compare and subtract steps
    always_comb begin
        t1   = {r_rem, r_q[NUM_W-1]};
        ge1  = (t1 >= {1'b0, r_dsr});
        rem1 = ge1 ? DSR_W'(t1 - {1'b0, r_dsr}) : DSR_W'(t1);
        t2   = {rem1, r_q[NUM_W-2]};
        ge2  = (t2 >= {1'b0, r_dsr});
        rem2 = ge2 ? DSR_W'(t2 - {1'b0, r_dsr}) : DSR_W'(t2);
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

    // datapath, dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dvd;
            r_rem <= '0;
            r_dsr <= i_req.dsr;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-3:0], ge1, ge2};
            r_rem <= rem2;
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == CNT_W'(DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

@@ src/tpli_back.sv @@
// tpli_back: evaluates jobs, forms both lines, determinant and numerators,
// drives the shared divider and holds the result beat; uses tpli_pkg
module tpli_back
    import tpli_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_job             i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output t_div_req         o_div,
    input  logic             i_div_done,
    input  logic [NUM_W-1:0] i_div_quo,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LINE  = 4'd1;
    localparam logic [3:0] S_PROD1 = 4'd2;
    localparam logic [3:0] S_COEF  = 4'd3;
    localparam logic [3:0] S_PROD2 = 4'd4;
    localparam logic [3:0] S_NUM   = 4'd5;
    localparam logic [3:0] S_DIVX  = 4'd6;
    localparam logic [3:0] S_DIVY  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]               r_state;
    logic                     r_start;
    logic                     r_out_valid;
    t_job                     r_job;
    t_result                  r_res;
    t_result                  r_out;
    logic signed [COEF_W-1:0] r_ua, r_ub, r_fa, r_fb;
    logic signed [C_W-1:0]    r_p1, r_p2, r_q1, r_q2, r_uc, r_fc;
    logic signed [DET_W-1:0]  r_det;
    logic                     r_perp;
    logic signed [PRD_W-1:0]  r_m1, r_m2, r_m3, r_m4;
    logic signed [NUM_W-1:0]  r_xn, r_yn;
    logic [NUM_W-1:0]         xn_mag, yn_mag;
    logic [DSR_W-1:0]         det_mag;
    logic [Q_W:0]             sat_x, sat_y;

    function automatic logic signed [COEF_W-1:0] sx(input logic [XY_W-1:0] v);
        return $signed({1'b0, v});
    endfunction

    // truncated magnitude to saturated signed quotient, flag on top
    function automatic logic [Q_W:0] sat_quo(input logic [NUM_W-1:0] mag,
                                             input logic neg);
        logic pos_ovf;
        logic neg_ovf;
        logic [Q_W:0] res;
        pos_ovf = |mag[NUM_W-1:Q_W-1];
        neg_ovf = (|mag[NUM_W-1:Q_W]) || (mag[Q_W-1] && (|mag[Q_W-2:0]));
        if (!neg) begin
            res = pos_ovf ? {1'b1, Q_MAX} : {1'b0, mag[Q_W-1:0]};
        end else begin
            res = neg_ovf ? {1'b1, Q_MIN} : {1'b0, Q_W'(-mag[Q_W-1:0])};
        end
        return res;
    endfunction

    // operand magnitudes for the divider
    always_comb begin
        xn_mag  = r_xn[NUM_W-1] ? NUM_W'($unsigned(-r_xn)) : NUM_W'($unsigned(r_xn));
        yn_mag  = r_yn[NUM_W-1] ? NUM_W'($unsigned(-r_yn)) : NUM_W'($unsigned(r_yn));
        det_mag = r_det[DET_W-1] ? DSR_W'($unsigned(-r_det)) : DSR_W'($unsigned(r_det));
        sat_x   = sat_quo(i_div_quo, r_xn[NUM_W-1] ^ r_det[DET_W-1]);
        sat_y   = sat_quo(i_div_quo, r_yn[NUM_W-1] ^ r_det[DET_W-1]);
    end

    assign o_div.start = r_start;
    assign o_div.dvd   = (r_state == S_DIVY) ? yn_mag : xn_mag;
    assign o_div.dsr   = det_mag;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_valid     = r_out_valid;
    assign o_res       = r_out;

    // evaluation sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // divider start after the numerators and after the x quotient
            r_start <= ((r_state == S_NUM) && (r_det != '0))
                       || ((r_state == S_DIVX) && i_div_done);
            if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_res   <= {{(RES_BITS - PH_W){1'b0}}, i_job.phase};
                        r_state <= i_job.eval ? S_LINE : S_OUT;
                    end
                end
                // coefficients a and b of both lines
                S_LINE: begin
                    r_ua         <= sx(r_job.y1) - sx(r_job.y2);
                    r_ub         <= sx(r_job.x2) - sx(r_job.x1);
                    r_fa         <= sx(i_cfg.sy) - sx(i_cfg.ey);
                    r_fb         <= sx(i_cfg.ex) - sx(i_cfg.sx);
                    r_res.coef_a <= sx(r_job.y1) - sx(r_job.y2);
                    r_res.coef_b <= sx(r_job.x2) - sx(r_job.x1);
                    r_state      <= S_PROD1;
                end
                // partial products of c, determinant and dot product
                S_PROD1: begin
                    r_p1   <= C_W'(sx(r_job.x1)) * C_W'(r_ua);
                    r_p2   <= C_W'(sx(r_job.y1)) * C_W'(r_ub);
                    r_q1   <= C_W'(sx(i_cfg.sx)) * C_W'(r_fa);
                    r_q2   <= C_W'(sx(i_cfg.sy)) * C_W'(r_fb);
                    r_det  <= DET_W'(r_ua) * DET_W'(r_fb) - DET_W'(r_fa) * DET_W'(r_ub);
                    r_perp <= (DET_W'(r_ua) * DET_W'(r_fa) + DET_W'(r_ub) * DET_W'(r_fb))
                              == '0;
                    r_state <= S_COEF;
                end
                S_COEF: begin
                    r_uc                   <= -r_p1 - r_p2;
                    r_fc                   <= -r_q1 - r_q2;
                    r_res.coef_c           <= -r_p1 - r_p2;
                    r_res.is_perpendicular <= r_perp;
                    r_state                <= S_PROD2;
                end
                // numerator products
                S_PROD2: begin
                    r_m1    <= PRD_W'(r_ub) * PRD_W'(r_fc);
                    r_m2    <= PRD_W'(r_fb) * PRD_W'(r_uc);
                    r_m3    <= PRD_W'(r_fa) * PRD_W'(r_uc);
                    r_m4    <= PRD_W'(r_ua) * PRD_W'(r_fc);
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_xn              <= NUM_W'(r_m1) - NUM_W'(r_m2);
                    r_yn              <= NUM_W'(r_m3) - NUM_W'(r_m4);
                    r_res.is_parallel <= (r_det == '0);
                    r_state           <= (r_det == '0) ? S_OUT : S_DIVX;
                end
                S_DIVX: begin
                    if (i_div_done) begin
                        r_res.cross_x   <= sat_x[Q_W-1:0];
                        r_res.saturated <= sat_x[Q_W];
                        r_state         <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (i_div_done) begin
                        r_res.cross_y        <= sat_y[Q_W-1:0];
                        r_res.saturated      <= r_res.saturated | sat_y[Q_W];
                        r_res.crossing_found <= 1'b1;
                        r_state              <= S_OUT;
                    end
                end
                // hand over to the output register
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX || r_state == S_DIVY) |-> (r_det != '0))
        else $error("divider running on zero determinant");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> (r_state == S_DIVX || r_state == S_DIVY))
        else $error("divider finished outside a divide state");
    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.crossing_found) |-> !r_out.is_parallel)
        else $error("crossing reported on parallel lines");
    a_sat_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.saturated) |-> r_out.crossing_found)
        else $error("saturation without a crossing");
`endif

endmodule

@@ src/two_point_line_intersection.sv @@
// two_point_line_intersection: top level with the config registers,
// front, job queue, shared divider and back end; uses tpli_pkg
//
//  channel   dir  handshake          payload
//  s stream  in   tvalid / tready    tdata point_x, point_y; tuser action
//  m stream  out  tvalid / tready    tdata result fields, 128 bits
//  config    in   psel/penable/...   four 12 bit reference line registers
//
// an evaluated point leaves the queue, then the back end forms the lines, c,
// determinant and numerators, runs each quotient through the shared divider
// (start, 20 two-bit steps, done) unless the lines are parallel, and loads the
// result beat; reset is synchronous, active low, no clearing pass
// the two entry job queue lets the front take beats while the back end works,
// and the output register holds a result until the sink takes it
module two_point_line_intersection
    import tpli_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // point_x, point_y
    input  logic [ACT_W-1:0]     i_s_tuser,  // action
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // phase, coef_a, coef_b, coef_c, cross_x, cross_y, crossing_found,
    // is_parallel, is_perpendicular, saturated, zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    localparam int PAD_W = M_TDATA_W - RES_BITS;

    t_cfg             r_cfg;
    logic [1:0]       reg_idx;
    logic             wr_en;
    logic             push, pop, full, empty;
    t_job             job_in, job_out;
    t_div_req         div_req;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    t_result          res;

    // config registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sx <= FSX_RST;
            r_cfg.sy <= FSY_RST;
            r_cfg.ex <= FEX_RST;
            r_cfg.ey <= FEY_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FSX: r_cfg.sx <= pwdata[XY_W-1:0];
                REG_FSY: r_cfg.sy <= pwdata[XY_W-1:0];
                REG_FEX: r_cfg.ex <= pwdata[XY_W-1:0];
                REG_FEY: r_cfg.ey <= pwdata[XY_W-1:0];
                default: r_cfg.sx <= r_cfg.sx;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_FSX: prdata = DATA_W'(r_cfg.sx);
            REG_FSY: prdata = DATA_W'(r_cfg.sy);
            REG_FEX: prdata = DATA_W'(r_cfg.ex);
            REG_FEY: prdata = DATA_W'(r_cfg.ey);
            default: prdata = '0;
        endcase
    end

    tpli_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_action (i_s_tuser),
        .i_px     (i_s_tdata[XY_W-1:0]),
        .i_py     (i_s_tdata[2*XY_W-1:XY_W]),
        .o_push   (push),
        .o_job    (job_in),
        .i_full   (full)
    );

    tpli_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    tpli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    tpli_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job      (job_out),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_div      (div_req),
        .i_div_done (div_done),
        .i_div_quo  (div_quo),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_res      (res)
    );

    // result beat packing, phase in the lowest bits
    assign o_m_tdata = {{PAD_W{1'b0}}, res.saturated, res.is_perpendicular,
                        res.is_parallel, res.crossing_found, res.cross_y,
                        res.cross_x, res.coef_c, res.coef_b, res.coef_a,
                        res.phase};

endmodule
